[sv/cdq_pkg.sv]
// Package for the circular deque unit.
// Holds the operation and status codes and the result descriptor struct.
// No dependencies; every other file imports it.
package cdq_pkg;

  // Operation carried by one input transfer.
  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_t;

  // Status returned with every result transfer.
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Width of the capacity register's write data.
  localparam int CAP_REG_WIDTH = 8;

  // What the control logic tells the output stage about one operation.
  typedef struct packed {
    status_t status;
    logic    pop_ok;
  } result_info_t;

endpackage

[sv/cdq_if.sv]
// Channel interfaces for the circular deque unit: operations in, results out.
// Depends on cdq_pkg for the status code type.
interface cdq_in_if #(
  parameter int VW = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic signed [VW-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cdq_out_if
  import cdq_pkg::*;
#(
  parameter int VW = 32
);
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic signed [VW-1:0] popped;

  modport source (output valid, output status, output popped, input ready);
  modport sink   (input valid, input status, input popped, output ready);
endinterface

[sv/cdq_mem.sv]
// Slot store of the deque: one write port and one read port with a
// registered read. Depends on cdq_pkg only through the common import.
module cdq_mem
  import cdq_pkg::*;
#(
  parameter int DEPTH       = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic signed [VALUE_WIDTH-1:0] wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic signed [VALUE_WIDTH-1:0] rdata
);

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/cdq_ctrl.sv]
// Index and occupancy control of the deque: capacity register, front and
// rear indices, empty flag, and the slot store request per operation.
// Depends on cdq_pkg for codes and the result descriptor.
module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int DEPTH       = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CAP_REG_WIDTH-1:0]      cfg_wdata,
  input  logic                          op_valid,
  input  logic [1:0]                    op_kind,
  input  logic signed [VALUE_WIDTH-1:0] op_value,
  output logic                          mem_we,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr,
  output logic signed [VALUE_WIDTH-1:0] mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr,
  output result_info_t                  info
);

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int LW      = (CW > CAP_REG_WIDTH) ? CW : CAP_REG_WIDTH;
  localparam int CAP_RST = (DEPTH < 128) ? DEPTH : 128;

  logic [CW-1:0] cap_r, cap_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] rear_r, rear_nxt;
  logic          empty_r, empty_nxt;

  logic [CW-1:0] front_inc, rear_inc;
  logic [AW-1:0] front_up, front_dn, rear_up, rear_dn;
  logic          full;
  logic [LW-1:0] cfg_ext;
  logic [CW-1:0] cfg_cap;
  kind_t         kind;

  // Neighbor indices, wrapping at the live capacity.
  assign front_inc = CW'(front_r) + CW'(1);
  assign rear_inc  = CW'(rear_r) + CW'(1);
  assign front_up  = (front_inc == cap_r) ? '0 : AW'(front_inc);
  assign rear_up   = (rear_inc == cap_r) ? '0 : AW'(rear_inc);
  assign front_dn  = (front_r == '0) ? AW'(cap_r - CW'(1)) : front_r - AW'(1);
  assign rear_dn   = (rear_r == '0) ? AW'(cap_r - CW'(1)) : rear_r - AW'(1);

  assign full = !empty_r && (front_r == rear_up);
  assign kind = kind_t'(op_kind);

  // Written capacity clamped to the range one to DEPTH.
  assign cfg_ext = LW'(cfg_wdata);
  always_comb begin
    if (cfg_ext == '0) begin
      cfg_cap = CW'(1);
    end else if (cfg_ext > LW'(DEPTH)) begin
      cfg_cap = CW'(DEPTH);
    end else begin
      cfg_cap = CW'(cfg_ext);
    end
  end

  // Next state and slot store request for one operation.
  always_comb begin
    cap_nxt     = cap_r;
    front_nxt   = front_r;
    rear_nxt    = rear_r;
    empty_nxt   = empty_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = op_value;
    mem_re      = 1'b0;
    mem_raddr   = front_r;
    info.status = STATUS_DONE;
    info.pop_ok = 1'b0;
    if (cfg_we) begin
      cap_nxt   = cfg_cap;
      front_nxt = '0;
      rear_nxt  = '0;
      empty_nxt = 1'b1;
    end else if (op_valid) begin
      case (kind)
        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
          if (full) begin
            info.status = STATUS_FULL;
          end else if (empty_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b0;
            mem_we    = 1'b1;
            mem_waddr = '0;
          end else if (kind == KIND_PUSH_FRONT) begin
            front_nxt = front_dn;
            mem_we    = 1'b1;
            mem_waddr = front_dn;
          end else begin
            rear_nxt  = rear_up;
            mem_we    = 1'b1;
            mem_waddr = rear_up;
          end
        end
        KIND_POP_FRONT, KIND_POP_REAR: begin
          if (empty_r) begin
            info.status = STATUS_EMPTY;
          end else begin
            mem_re      = 1'b1;
            mem_raddr   = (kind == KIND_POP_FRONT) ? front_r : rear_r;
            info.pop_ok = 1'b1;
            if (front_r == rear_r) begin
              front_nxt = '0;
              rear_nxt  = '0;
              empty_nxt = 1'b1;
            end else if (kind == KIND_POP_FRONT) begin
              front_nxt = front_up;
            end else begin
              rear_nxt = rear_dn;
            end
          end
        end
        default: begin
          info.status = STATUS_DONE;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CW'(CAP_RST);
      front_r <= '0;
      rear_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      cap_r   <= cap_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule

[sv/circular_deque_unit.sv]
// Circular deque unit: a double-ended queue of signed values held in a
// slot memory whose active size is set by the capacity register.
// Each transfer on in_ch carries one operation (push front, push rear,
// pop front, pop rear) and produces exactly one transfer on out_ch with a
// status (done, full, empty) and, for a successful pop, the removed value;
// popped is zero otherwise.
// out_ch.valid rises in the cycle after the input transfer, and one
// operation is taken every cycle while the receiver takes each result:
// the indices update at the input transfer and the slot memory's single
// read or write happens in the same cycle, so the registered read data
// is the result. When the receiver stalls, the result holds in the output
// register and in_ch.ready drops until it is taken; ready returns in the
// cycle the result is taken, so a new operation can enter as it leaves.
// cfg_we writes the capacity (zero acts as one, values above DEPTH as
// DEPTH) and empties the deque; write it only while the unit is idle.
// Reset sets capacity to 128 (or DEPTH if smaller) and empties the deque;
// slot contents are left as they are and need no clearing pass.
// Depends on cdq_pkg, cdq_if, cdq_mem and cdq_ctrl.
module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int DEPTH       = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CAP_REG_WIDTH-1:0] cfg_wdata,
  cdq_in_if.sink                   in_ch,
  cdq_out_if.source                out_ch
);

  localparam int AW = $clog2(DEPTH);

  logic                          accept;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic signed [VALUE_WIDTH-1:0] mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic signed [VALUE_WIDTH-1:0] mem_rdata;
  result_info_t                  info;

  logic         out_valid_r, out_valid_nxt;
  result_info_t res_r;

  // Input transfer when the output register is free or being emptied.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  cdq_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op_valid  (accept),
    .op_kind   (in_ch.kind),
    .op_value  (in_ch.value),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .info      (info)
  );

  cdq_mem #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output valid: set by an input transfer, cleared by an output transfer.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result descriptor; the popped value itself sits in the memory read register.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= info;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = res_r.status;
  assign out_ch.popped = res_r.pop_ok ? mem_rdata : '0;

endmodule
